@@ rtl/tdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// Types and codes shared by the table-driven DFA recognizer modules.
// ----------------------------------------------------------------------------
package tdr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DEFINE = 2'd1,
    OP_FEED   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } back_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] state_id;
    logic [7:0] symbol;
    logic [3:0] dest_state;
    logic       accept_flag;
    logic       last_symbol;
  } in_item_t;

  typedef struct packed {
    logic [3:0] from_state;
    logic [3:0] to_state;
    logic       matched;
    logic       end_of_string;
    logic       accepted;
    logic       is_dead;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t        op;
    logic [3:0] sid;
    logic [7:0] sym;
    logic [3:0] dst;
    logic       acc;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

@@ rtl/tdr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_front
// Accepts input words, decodes the operation and wraps state ids.
// ----------------------------------------------------------------------------
module tdr_front #(
  parameter int NUM_STATES = 16
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  tdr_pkg::in_item_t in_item,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output tdr_pkg::cmd_t     cmd
);

  function automatic logic [3:0] wrap(input logic [3:0] v);
    logic [4:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (int'(t) >= NUM_STATES) t = t - 5'(NUM_STATES);
    end
    return t[3:0];
  endfunction

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    cmd.op   = tdr_pkg::op_t'(in_item.operation);
    cmd.sid  = wrap(in_item.state_id);
    cmd.sym  = in_item.symbol;
    cmd.dst  = wrap(in_item.dest_state);
    cmd.acc  = in_item.accept_flag;
    cmd.last = in_item.last_symbol;
  end

endmodule

@@ rtl/tdr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module tdr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tdr_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output tdr_pkg::cmd_t       head,
  output tdr_pkg::q_status_t  status
);

  tdr_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  assign head         = slots[rd_ptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

endmodule

@@ rtl/tdr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_back
// Executes commands against the transition memory and state tables, and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module tdr_back #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  tdr_pkg::q_status_t  q_status,
  input  tdr_pkg::cmd_t       q_head,
  output logic                pop,
  input  logic [3:0]          init_state,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output tdr_pkg::out_item_t  out_item
);

  localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW    = SW + SYMBOL_BITS;
  localparam int DEPTH = NUM_STATES << SYMBOL_BITS;
  localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;

  // entry = {valid, next state}
  logic [4:0]          mem [DEPTH];
  logic [4:0]          rd_data;
  logic                mem_re, mem_we;
  logic [AW-1:0]       ra, wa, clr_ptr;
  logic [4:0]          wd;

  logic [NUM_STATES-1:0] st_defined, st_accepting;
  logic [8:0]            exit_count [NUM_STATES];
  logic [3:0]            cur_state;

  tdr_pkg::back_state_t state, state_next;
  tdr_pkg::cmd_t        cmd;

  logic       out_free, fire;
  logic [3:0] to_st;
  logic [SW-1:0] sid_ix, flag_ix;
  logic [8:0] cnt_old, cnt_new;
  logic       hit;

  function automatic logic [AW-1:0] addr(input logic [3:0] st, input logic [7:0] sy);
    logic [SW-1:0] s;
    s = SW'(st);
    return {s, sy[SYMBOL_BITS-1:0]};
  endfunction

  assign out_free = ~out_valid | ~out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tdr_pkg::S_CLEAR: if (clr_ptr == AW'(DEPTH - 1)) state_next = tdr_pkg::S_IDLE;
      tdr_pkg::S_IDLE:  if (q_status.valid) state_next = tdr_pkg::S_EXEC;
      tdr_pkg::S_EXEC:  if (out_free) state_next = tdr_pkg::S_IDLE;
      default:          state_next = tdr_pkg::S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clearing = 1'b0;
    pop      = 1'b0;
    fire     = 1'b0;
    unique case (state)
      tdr_pkg::S_CLEAR: clearing = 1'b1;
      tdr_pkg::S_IDLE:  pop = q_status.valid;
      tdr_pkg::S_EXEC:  fire = out_free;
      default:          clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tdr_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst)           clr_ptr <= '0;
    else if (clearing) clr_ptr <= clr_ptr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (pop) cmd <= q_head;
  end

  // memory ports
  assign mem_re = pop;
  assign ra     = (q_head.op == tdr_pkg::OP_FEED) ? addr(cur_state, q_head.sym)
                                                   : addr(q_head.sid, q_head.sym);
  assign mem_we = clearing | (fire & (cmd.op == tdr_pkg::OP_LOAD));
  assign wa     = clearing ? clr_ptr : addr(cmd.sid, cmd.sym);
  assign wd     = clearing ? 5'd0 : {1'b1, cmd.dst};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa] <= wd;
    if (mem_re) rd_data <= mem[ra];
  end

  // execute
  assign hit     = (cmd.op == tdr_pkg::OP_FEED) & rd_data[4];
  assign to_st   = hit ? rd_data[3:0] : cur_state;
  assign sid_ix  = SW'(cmd.sid);
  assign flag_ix = (cmd.op == tdr_pkg::OP_FEED) ? SW'(to_st) : sid_ix;
  assign cnt_old = exit_count[sid_ix];

  always_comb begin
    cnt_new = cnt_old;
    if (rd_data[4] && rd_data[3:0] != cmd.sid && cnt_new != 9'd0) cnt_new = cnt_new - 9'd1;
    if (cmd.dst != cmd.sid) cnt_new = cnt_new + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_defined   <= '0;
      st_accepting <= '0;
      cur_state    <= 4'd0;
      for (int i = 0; i < NUM_STATES; i++) exit_count[i] <= 9'd0;
    end else if (fire) begin
      unique case (cmd.op)
        tdr_pkg::OP_LOAD:   exit_count[sid_ix] <= cnt_new;
        tdr_pkg::OP_DEFINE: begin
          st_defined[sid_ix]   <= 1'b1;
          st_accepting[sid_ix] <= cmd.acc;
        end
        tdr_pkg::OP_FEED:   cur_state <= cmd.last ? init_state : to_st;
        tdr_pkg::OP_QUERY:  ;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (fire)     out_valid <= 1'b1;
    else if (~out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.from_state    <= cur_state;
      out_item.to_state      <= to_st;
      out_item.matched       <= hit;
      out_item.end_of_string <= (cmd.op == tdr_pkg::OP_FEED) & cmd.last;
      out_item.accepted      <= (cmd.op == tdr_pkg::OP_FEED) & cmd.last &
                                st_defined[flag_ix] & st_accepting[flag_ix];
      out_item.is_dead       <= (cmd.op == tdr_pkg::OP_QUERY) & st_defined[flag_ix] &
                                (cnt_old == 9'd0);
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop && !fire)
    else $error("command taken during clearing pass");

  a_pop_then_exec: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == tdr_pkg::S_EXEC)
    else $error("popped command not executed");

  a_fire_gives_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result word lost");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == tdr_pkg::S_EXEC |-> cnt_old <= 9'(NUM_SYMBOLS))
    else $error("exit count out of range");

endmodule

@@ rtl/table_driven_dfa_recognizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_dfa_recognizer
// Programmable DFA: loads transitions and accept flags, steps on symbols,
// reports acceptance at end of string and answers dead-state queries.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | in_item  (tdr_pkg::in_item_t)
//  out      | out_valid/out_stall| out_item (tdr_pkg::out_item_t)
//  cfg      | cfg_wr_en          | cfg_wr_data (initial_state)
//
// In the back end each word passes through a registered read of the
// transition memory, then the update and the result register write.
// After reset a clearing pass wipes all NUM_STATES << SYMBOL_BITS entries
// of transition memory (4096 by default); in_stall stays high meanwhile.
// A stalled output holds the back end; the two-entry queue keeps taking
// words until it fills.
// ----------------------------------------------------------------------------
module table_driven_dfa_recognizer #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tdr_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);

  logic [3:0]         initial_state;
  logic               push, pop, clearing;
  tdr_pkg::cmd_t      push_cmd, head;
  tdr_pkg::q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst)            initial_state <= 4'd0;
    else if (cfg_wr_en) initial_state <= cfg_wr_data;
  end

  tdr_front #(.NUM_STATES(NUM_STATES)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_status.full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  tdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  tdr_back #(.NUM_STATES(NUM_STATES), .SYMBOL_BITS(SYMBOL_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .q_head     (head),
    .pop        (pop),
    .init_state (initial_state),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
